>>> rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes of the LRU block buffer cache tag manager.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // request opcodes
  localparam logic [2:0] OP_GET       = 3'd0;
  localparam logic [2:0] OP_RELEASE   = 3'd1;
  localparam logic [2:0] OP_FLUSH_ONE = 3'd2;
  localparam logic [2:0] OP_FLUSH_ALL = 3'd3;
  localparam logic [2:0] OP_FILL_FAIL = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_GRANT     = 3'd0;
  localparam logic [2:0] KIND_WRITEBACK = 3'd1;
  localparam logic [2:0] KIND_READ      = 3'd2;
  localparam logic [2:0] KIND_ACK       = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  localparam logic [31:0] TAG_INVALID = 32'hffff_ffff;
  localparam logic [7:0]  COUNT_MAX   = 8'hff;
  localparam logic [15:0] AGE_BIAS    = 16'h8000;

  // target index sources
  localparam logic [1:0] TGT_IDX  = 2'd0;
  localparam logic [1:0] TGT_HIT  = 2'd1;
  localparam logic [1:0] TGT_PICK = 2'd2;
  localparam logic [1:0] TGT_CNT  = 2'd3;

  // row update modes
  localparam logic [2:0] WR_GET_HIT  = 3'd0;
  localparam logic [2:0] WR_GET_MISS = 3'd1;
  localparam logic [2:0] WR_RELEASE  = 3'd2;
  localparam logic [2:0] WR_CLEAN    = 3'd3;
  localparam logic [2:0] WR_FILL     = 3'd4;

  // block field source of a result
  localparam logic [1:0] BLK_ZERO = 2'd0;
  localparam logic [1:0] BLK_ITEM = 2'd1;
  localparam logic [1:0] BLK_TAG  = 2'd2;

  // one buffer's tag state
  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] stamp;
    logic [7:0]  count;
    logic        dirty;
  } row_t;

  localparam row_t RESET_ROW = '{tag: TAG_INVALID, stamp: 16'd0, count: 8'd0, dirty: 1'b0};

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       scan_clr;
    logic       rd_cnt;
    logic       eval;
    logic       cnt_inc;
    logic       rd_tgt;
    logic       tgt_load;
    logic [1:0] tgt_sel;
    logic       wr_en;
    logic [2:0] wr_mode;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_last;
    logic       emit_buf_zero;
    logic [1:0] emit_blk_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       idx_bad;
    logic       count_zero;
    logic       count_max;
    logic       dirty;
    logic       hit_found;
    logic       pick_found;
    logic       cnt_last;
    logic       out_free;
  } status_t;

endpackage

>>> rtl/block_buffer_cache_lru.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Tag manager of an LRU block buffer cache: get, release, flush, fill failure.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   request: opcode, block_number, buffer_index, write_flag
// m_*      out  result: kind, out_buffer, out_block; tlast = last
//
// Get scans the tag RAM read port one row a cycle for match and LRU, then reads
// the target row. Release, flush one, fill failed read the indexed row directly.
// Flush all reads each row in turn and writes back and cleans the dirty ones.
// Reset clears all buffers at once through per-row valid bits; no sweep.
// A stalled result output holds the sequencer; one request is handled at a time.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru
  import bbc_pkg::*;
#(
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // opcode[2:0], block_number[34:3], buffer_index[38:35],
                                 // write_flag[39]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // kind[2:0], out_buffer[6:3], out_block[38:7], zero[39]
  output logic        m_tlast    // last
);

  cmd_t    cmd;
  status_t sts;

  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbc_datapath #(.NUM_BUFFERS(NUM_BUFFERS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bbc_datapath.sv
// ----------------------------------------------------------------------------
// bbc_datapath
// Tag RAM, valid bits, scan counter, hit and LRU tracking, output register.
// ----------------------------------------------------------------------------
module bbc_datapath
  import bbc_pkg::*;
#(
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // kind[2:0], out_buffer[6:3], out_block[38:7], zero[39]
  output logic        m_tlast    // last
);

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);

  // captured request
  logic [2:0]  op_q;
  logic [31:0] block_q;
  logic [3:0]  idx_q;
  logic        wr_q;

  logic [IW-1:0] cnt, tgt, ev_idx, hit_idx, pick_idx;
  logic          ev_v, hit_found, pick_found;
  logic [15:0]   pick_key, seq;
  logic [NUM_BUFFERS-1:0] vld;
  logic          vld_q;
  row_t          ram_q, row, wr_row;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic [15:0]   ev_key;
  logic [7:0]    count_dec;
  logic          out_free;
  logic [31:0]   emit_blk;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q    <= s_tdata[2:0];
      block_q <= s_tdata[34:3];
      idx_q   <= s_tdata[38:35];
      wr_q    <= s_tdata[39];
    end
  end

  // read port: scan counter or target
  assign rd_en   = cmd.rd_cnt | cmd.rd_tgt;
  assign rd_addr = cmd.rd_cnt ? cnt : tgt;

  bbc_ram #(.WIDTH($bits(row_t)), .DEPTH(NUM_BUFFERS)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (tgt),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // valid bits: a never-written row reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.wr_en) begin
      vld[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q <= vld[rd_addr];
    end
  end

  assign row = vld_q ? ram_q : RESET_ROW;

  // scan counter and target
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.tgt_load) begin
      unique case (cmd.tgt_sel)
        TGT_IDX:  tgt <= IW'(idx_q);
        TGT_HIT:  tgt <= hit_idx;
        TGT_PICK: tgt <= pick_idx;
        TGT_CNT:  tgt <= cnt;
        default:  tgt <= cnt;
      endcase
    end
  end

  // scan evaluation, one row a cycle, in the cycle after the row is read
  assign ev_key = (seq - row.stamp) ^ AGE_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_v       <= 1'b0;
      hit_found  <= 1'b0;
      pick_found <= 1'b0;
    end else begin
      ev_v <= cmd.rd_cnt & cmd.eval;
      if (cmd.scan_clr) begin
        hit_found  <= 1'b0;
        pick_found <= 1'b0;
      end else if (ev_v) begin
        if (!hit_found && row.tag == block_q) begin
          hit_found <= 1'b1;
        end
        if (row.count == 8'd0 && (!pick_found || ev_key > pick_key)) begin
          pick_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= cnt;
    if (ev_v && !hit_found && row.tag == block_q) begin
      hit_idx <= ev_idx;
    end
    if (ev_v && row.count == 8'd0 && (!pick_found || ev_key > pick_key)) begin
      pick_idx <= ev_idx;
      pick_key <= ev_key;
    end
  end

  // row update
  assign count_dec = row.count - 8'd1;

  always_comb begin
    wr_row = row;
    unique case (cmd.wr_mode)
      WR_GET_HIT: wr_row.count = row.count + 8'd1;
      WR_GET_MISS: begin
        wr_row.tag   = block_q;
        wr_row.count = row.count + 8'd1;
        wr_row.dirty = 1'b0;
      end
      WR_RELEASE: begin
        wr_row.dirty = row.dirty | wr_q;
        wr_row.count = count_dec;
        if (count_dec == 8'd0) begin
          wr_row.stamp = seq + 16'd1;
        end
      end
      WR_CLEAN: wr_row.dirty = 1'b0;
      WR_FILL: begin
        wr_row.tag   = TAG_INVALID;
        wr_row.count = count_dec;
      end
      default: wr_row = row;
    endcase
  end

  // release sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (cmd.wr_en && cmd.wr_mode == WR_RELEASE && count_dec == 8'd0) begin
      seq <= seq + 16'd1;
    end
  end

  // result register
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    unique case (cmd.emit_blk_sel)
      BLK_ITEM: emit_blk = block_q;
      BLK_TAG:  emit_blk = row.tag;
      default:  emit_blk = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {1'b0, emit_blk, (cmd.emit_buf_zero ? 4'd0 : 4'(tgt)), cmd.emit_kind};
      m_tlast <= cmd.emit_last;
    end
  end

  // status
  assign sts.op         = op_q;
  assign sts.idx_bad    = 32'(idx_q) >= 32'(NUM_BUFFERS);
  assign sts.count_zero = row.count == 8'd0;
  assign sts.count_max  = row.count == COUNT_MAX;
  assign sts.dirty      = row.dirty;
  assign sts.hit_found  = hit_found;
  assign sts.pick_found = pick_found;
  assign sts.cnt_last   = cnt == LAST_IDX;
  assign sts.out_free   = out_free;

  a_emit_free: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> out_free)
    else $error("result emitted over a pending one");
  a_hit_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(hit_found) |-> $past(ev_v))
    else $error("hit recorded outside a scan");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= LAST_IDX)
    else $error("scan counter out of range");

endmodule

>>> rtl/bbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer: scan, decide, read target row, update and emit results.
// ----------------------------------------------------------------------------
module bbc_ctrl
  import bbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_RD       = 4'd5;
  localparam logic [3:0] S_EXEC     = 4'd6;
  localparam logic [3:0] S_READ_CMD = 4'd7;
  localparam logic [3:0] S_GRANT    = 4'd8;
  localparam logic [3:0] S_ACK      = 4'd9;
  localparam logic [3:0] S_ERR      = 4'd10;
  localparam logic [3:0] S_FL_RD    = 4'd11;
  localparam logic [3:0] S_FL_EV    = 4'd12;
  localparam logic [3:0] S_FL_ACK   = 4'd13;

  logic [3:0] state, state_next;
  logic       hit, hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      hit   <= hit_next;
    end
  end

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    hit_next   = hit;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          cmd.scan_clr  = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.op == OP_GET) begin
          state_next = S_SCAN;
        end else if (sts.op == OP_FLUSH_ALL) begin
          state_next = S_FL_RD;
        end else if (sts.op > OP_FILL_FAIL || sts.idx_bad) begin
          state_next = S_ERR;
        end else begin
          cmd.tgt_load = 1'b1;
          cmd.tgt_sel  = TGT_IDX;
          state_next   = S_RD;
        end
      end
      S_SCAN: begin
        cmd.rd_cnt = 1'b1;
        cmd.eval   = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_SCAN_END;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_SCAN_END: state_next = S_DECIDE;
      S_DECIDE: begin
        cmd.tgt_load = 1'b1;
        priority if (sts.hit_found) begin
          cmd.tgt_sel = TGT_HIT;
          hit_next    = 1'b1;
          state_next  = S_RD;
        end else if (sts.pick_found) begin
          cmd.tgt_sel = TGT_PICK;
          hit_next    = 1'b0;
          state_next  = S_RD;
        end else begin
          state_next = S_ERR;
        end
      end
      S_RD: begin
        cmd.rd_tgt = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_GET: begin
            if (hit) begin
              if (sts.count_max) begin
                state_next = S_ERR;
              end else if (sts.out_free) begin
                cmd.wr_en        = 1'b1;
                cmd.wr_mode      = WR_GET_HIT;
                cmd.emit         = 1'b1;
                cmd.emit_kind    = KIND_GRANT;
                cmd.emit_blk_sel = BLK_ITEM;
                cmd.emit_last    = 1'b1;
                state_next       = S_IDLE;
              end
            end else if (!sts.dirty || sts.out_free) begin
              cmd.emit         = sts.dirty;
              cmd.emit_kind    = KIND_WRITEBACK;
              cmd.emit_blk_sel = BLK_TAG;
              cmd.wr_en        = 1'b1;
              cmd.wr_mode      = WR_GET_MISS;
              state_next       = S_READ_CMD;
            end
          end
          OP_RELEASE: begin
            if (sts.count_zero) begin
              state_next = S_ERR;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_mode = WR_RELEASE;
              state_next  = S_ACK;
            end
          end
          OP_FLUSH_ONE: begin
            if (!sts.dirty) begin
              state_next = S_ACK;
            end else if (sts.out_free) begin
              cmd.emit         = 1'b1;
              cmd.emit_kind    = KIND_WRITEBACK;
              cmd.emit_blk_sel = BLK_TAG;
              cmd.wr_en        = 1'b1;
              cmd.wr_mode      = WR_CLEAN;
              state_next       = S_ACK;
            end
          end
          default: begin
            if (sts.count_zero) begin
              state_next = S_ERR;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_mode = WR_FILL;
              state_next  = S_ACK;
            end
          end
        endcase
      end
      S_READ_CMD: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_kind    = KIND_READ;
          cmd.emit_blk_sel = BLK_ITEM;
          state_next       = S_GRANT;
        end
      end
      S_GRANT: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_kind    = KIND_GRANT;
          cmd.emit_blk_sel = BLK_ITEM;
          cmd.emit_last    = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_ACK: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_kind    = KIND_ACK;
          cmd.emit_blk_sel = BLK_ZERO;
          cmd.emit_last    = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit          = 1'b1;
          cmd.emit_kind     = KIND_ERROR;
          cmd.emit_blk_sel  = BLK_ZERO;
          cmd.emit_buf_zero = 1'b1;
          cmd.emit_last     = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_FL_RD: begin
        cmd.rd_cnt   = 1'b1;
        cmd.tgt_load = 1'b1;
        cmd.tgt_sel  = TGT_CNT;
        state_next   = S_FL_EV;
      end
      S_FL_EV: begin
        if (!sts.dirty || sts.out_free) begin
          cmd.emit         = sts.dirty;
          cmd.emit_kind    = KIND_WRITEBACK;
          cmd.emit_blk_sel = BLK_TAG;
          cmd.wr_en        = sts.dirty;
          cmd.wr_mode      = WR_CLEAN;
          if (sts.cnt_last) begin
            state_next = S_FL_ACK;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_FL_RD;
          end
        end
      end
      S_FL_ACK: begin
        if (sts.out_free) begin
          cmd.emit          = 1'b1;
          cmd.emit_kind     = KIND_ACK;
          cmd.emit_blk_sel  = BLK_ZERO;
          cmd.emit_buf_zero = 1'b1;
          cmd.emit_last     = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_CHECK)
    else $error("accepted request did not start decoding");
  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_cnt && cmd.rd_tgt))
    else $error("two reads in one cycle");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_last) |=> state == S_IDLE)
    else $error("final result without return to idle");

endmodule
